/* hdl/hnlt_pkg.sv */
// Package for the heartbeat node liveness table.
// Holds table sizes, field widths, request and register codes and the shared types.
// Used by every module of the block; depends on nothing.
package hnlt_pkg;

	// Table geometry and field widths.
	localparam int NODE_SLOTS     = 8;
	localparam int IDX_W          = 3;
	localparam int NODE_W         = 8;
	localparam int AGE_W          = 18;
	localparam int LIVE_W         = 4;
	localparam int TIMEOUT_W      = 16;
	localparam int STATUS_W       = 8;
	localparam int TICK_PERIOD_MS = 2;
	localparam int AGE_LIMIT_FACTOR = 3;
	localparam int FAULT_BIT      = 0;
	localparam logic [AGE_W-1:0] AGE_STEP = AGE_W'(2);

	// Stream payload widths.
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Request kinds carried in the input tuser.
	typedef enum logic [1:0] {
		REQ_HEARTBEAT = 2'd0,
		REQ_TICK      = 2'd1,
		REQ_CLEAR     = 2'd2,
		REQ_UNUSED    = 2'd3
	} req_t;

	// Register indexes (word address).
	typedef enum logic [1:0] {
		REG_MASTER_MODE = 2'd0,
		REG_TIMEOUT_MS  = 2'd1,
		REG_REPORT_LOSS = 2'd2,
		REG_MASTER_ID   = 2'd3
	} reg_idx_t;

	localparam logic [NODE_W-1:0] MASTER_ID_RESET = NODE_W'(63);

	typedef struct packed {
		logic                 master_mode;
		logic [TIMEOUT_W-1:0] timeout_ms;
		logic                 report_loss;
		logic [NODE_W-1:0]    master_node_id;
	} cfg_t;

	// Operations on the slot table.
	typedef enum logic [1:0] {
		SOP_NONE  = 2'd0,
		SOP_TAKE  = 2'd1,
		SOP_AGE   = 2'd2,
		SOP_CLEAR = 2'd3
	} slot_op_t;

	typedef struct packed {
		slot_op_t          op;
		logic [IDX_W-1:0]  idx;
		logic [NODE_W-1:0] id;
		logic [AGE_W-1:0]  limit;
	} slot_cmd_t;

	typedef struct packed {
		logic is_free;
		logic id_match;
		logic expired;
	} slot_stat_t;

endpackage

/* hdl/hnlt_slot_unit.sv */
// Slot table of node ids and ages with the shared compare and aging unit.
// One slot is examined or updated per cycle at the index the sequencer gives.
// A clear empties every slot's node id at once. Depends on hnlt_pkg.
module hnlt_slot_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  hnlt_pkg::slot_cmd_t cmd,
	output hnlt_pkg::slot_stat_t stat
);
	import hnlt_pkg::*;

	logic [NODE_W-1:0] slot_node_q [NODE_SLOTS];
	logic [AGE_W-1:0]  slot_age_q  [NODE_SLOTS];

	logic [NODE_W-1:0] sel_node;
	logic [AGE_W-1:0]  age_next;

	// Shared unit: compare the selected slot and compute its next age.
	always_comb begin
		sel_node      = slot_node_q[cmd.idx];
		age_next      = slot_age_q[cmd.idx] + AGE_STEP;
		stat.is_free  = (sel_node == '0);
		stat.id_match = (sel_node == cmd.id);
		stat.expired  = (age_next > cmd.limit);
	end

	// Table update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_SLOTS; i++) begin
				slot_node_q[i] <= '0;
				slot_age_q[i]  <= '0;
			end
		end else begin
			case (cmd.op)
				SOP_TAKE: begin
					slot_node_q[cmd.idx] <= cmd.id;
					slot_age_q[cmd.idx]  <= '0;
				end
				SOP_AGE: begin
					if (!stat.is_free) begin
						if (stat.expired) begin
							slot_node_q[cmd.idx] <= '0;
							slot_age_q[cmd.idx]  <= '0;
						end else begin
							slot_age_q[cmd.idx] <= age_next;
						end
					end
				end
				SOP_CLEAR: begin
					for (int i = 0; i < NODE_SLOTS; i++) begin
						slot_node_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* hdl/hnlt_ctrl.sv */
// Sequencer of the heartbeat table: takes a request, walks the slots and builds the result.
// Holds the beat counter, the live count and the output register.
// Depends on hnlt_pkg.
module hnlt_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hnlt_pkg::cfg_t                  cfg,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: node_id[7:0], slave_status[15:8], send_ok[16], motor_running[17], zero pad
	input  logic [hnlt_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [hnlt_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: send_beat[0], slave_fault[1], slave_lost[2], no_slave_error[3],
	//          table_full[4], live_count[8:5], zero pad
	output logic [hnlt_pkg::M_TDATA_W-1:0]  m_tdata,
	output hnlt_pkg::slot_cmd_t             cmd,
	input  hnlt_pkg::slot_stat_t            stat
);
	import hnlt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_HB_SCAN   = 5'b00010,
		ST_HB_WRITE  = 5'b00100,
		ST_TICK_SCAN = 5'b01000,
		ST_FINISH    = 5'b10000
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]     idx_q;
	logic [NODE_W-1:0]    id_q;
	logic                 running_q;
	logic                 send_q;
	logic                 fault_q;
	logic                 lost_q;
	logic                 no_slave_q;
	logic                 full_q;
	logic                 found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [LIVE_W-1:0]    count_q;
	logic [TIMEOUT_W-1:0] beat_count_q;
	logic [LIVE_W-1:0]    live_q;
	logic [AGE_W-1:0]     limit_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                 in_xfer;
	req_t                 in_req;
	logic [NODE_W-1:0]    in_node;
	logic [STATUS_W-1:0]  in_status;
	logic                 in_send_ok;
	logic                 in_running;
	logic                 last_slot;
	logic                 out_free;
	logic [TIMEOUT_W-1:0] beat_inc;
	logic [TIMEOUT_W-1:0] interval;
	logic [AGE_W-1:0]     limit;
	logic [LIVE_W-1:0]    count_next;
	logic                 hb_take;
	logic                 tick_take;
	logic                 beat_due;

	// Input unpacking and derived values.
	always_comb begin
		in_req     = req_t'(s_tuser);
		in_node    = s_tdata[NODE_W-1:0];
		in_status  = s_tdata[NODE_W +: STATUS_W];
		in_send_ok = s_tdata[NODE_W+STATUS_W];
		in_running = s_tdata[NODE_W+STATUS_W+1];
		s_tready   = (state_q == ST_IDLE);
		in_xfer    = s_tvalid && s_tready;
		last_slot  = (idx_q == IDX_W'(NODE_SLOTS - 1));
		out_free   = !m_tvalid_q || m_tready;
		beat_inc   = beat_count_q + TIMEOUT_W'(1);
		interval   = TIMEOUT_W'(cfg.timeout_ms / TICK_PERIOD_MS);
		limit      = AGE_W'((AGE_W'(cfg.timeout_ms) * AGE_W'(AGE_LIMIT_FACTOR))
			/ TICK_PERIOD_MS);
		count_next = count_q + LIVE_W'(!stat.is_free && !stat.expired);
		hb_take    = (in_req == REQ_HEARTBEAT) && cfg.master_mode
			&& (in_node != cfg.master_node_id);
		tick_take  = (in_req == REQ_TICK) && cfg.master_mode;
		beat_due   = (beat_inc >= interval);
	end

	// Command to the slot table.
	always_comb begin
		cmd.op    = SOP_NONE;
		cmd.idx   = idx_q;
		cmd.id    = id_q;
		cmd.limit = limit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && in_req == REQ_CLEAR) begin
					cmd.op = SOP_CLEAR;
				end
			end
			ST_HB_WRITE: begin
				cmd.idx = found_q ? match_idx_q : free_idx_q;
				if (found_q || free_found_q) begin
					cmd.op = SOP_TAKE;
				end
			end
			ST_TICK_SCAN: begin
				cmd.op = SOP_AGE;
			end
			ST_HB_SCAN, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			id_q         <= '0;
			running_q    <= 1'b0;
			send_q       <= 1'b0;
			fault_q      <= 1'b0;
			lost_q       <= 1'b0;
			no_slave_q   <= 1'b0;
			full_q       <= 1'b0;
			found_q      <= 1'b0;
			match_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			count_q      <= '0;
			beat_count_q <= '0;
			live_q       <= '0;
			limit_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// The output register loads a new result or drops the one just taken.
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						id_q         <= in_node;
						running_q    <= in_running;
						send_q       <= tick_take && beat_due && in_send_ok;
						fault_q      <= hb_take && in_status[FAULT_BIT];
						lost_q       <= 1'b0;
						no_slave_q   <= 1'b0;
						full_q       <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						idx_q        <= '0;
						count_q      <= '0;
						limit_q      <= limit;
						if (hb_take && in_node != '0) begin
							state_q <= ST_HB_SCAN;
						end else if (tick_take) begin
							state_q <= ST_TICK_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
						// A refused beat keeps the count so it is retried.
						if (tick_take) begin
							if (!beat_due) begin
								beat_count_q <= beat_inc;
							end else if (in_send_ok) begin
								beat_count_q <= '0;
							end
						end
						// A clear, or a tick outside master mode, empties the live count.
						if (in_req == REQ_CLEAR || (in_req == REQ_TICK && !cfg.master_mode)) begin
							live_q <= '0;
						end
					end
				end
				ST_HB_SCAN: begin
					// Remember the first matching slot and the first free slot.
					if (stat.id_match && !found_q) begin
						found_q     <= 1'b1;
						match_idx_q <= idx_q;
					end
					if (stat.is_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					idx_q <= idx_q + IDX_W'(1);
					if (last_slot) begin
						state_q <= ST_HB_WRITE;
					end
				end
				ST_HB_WRITE: begin
					if (!found_q && !free_found_q) begin
						full_q <= 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_TICK_SCAN: begin
					// Age one slot per cycle and count the survivors.
					if (!stat.is_free && stat.expired && cfg.report_loss) begin
						lost_q <= 1'b1;
					end
					count_q <= count_next;
					idx_q   <= idx_q + IDX_W'(1);
					if (last_slot) begin
						live_q     <= count_next;
						no_slave_q <= (count_next == '0) && running_q;
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= {(M_TDATA_W - 5 - LIVE_W)'(0), live_q, full_q, no_slave_q,
				lost_q, fault_q, send_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* hdl/heartbeat_node_liveness_table_top.sv */
// Top level of the heartbeat node liveness table: configuration registers and wiring.
// Instantiates hnlt_ctrl and hnlt_slot_unit; depends on hnlt_pkg.
//
// Usage. Requests enter on the s_ stream: tuser carries the request kind (heartbeat,
// tick, clear) and tdata the node id, status byte, send_ok and motor_running flags.
// Each accepted request gives exactly one result transfer on the m_ stream with the
// beat, fault, loss, no-slave and table-full flags and the live node count.
// Configuration is written over the APB port (master_mode, timeout_ms, report_loss,
// master_node_id at word addresses 0 to 3); the user must write it only while no request
// is in flight, which the block does not enforce. After a heartbeat transfer m_tvalid
// rises once every slot has been searched, the matching or free slot updated and the
// output register loaded; after a tick, once every slot has been aged and the output
// register loaded; after a clear, an ignored request or a heartbeat from node 0, once
// the output register is loaded. The slot walk through the single shared compare and
// aging unit sets this order; one request is in work at a time.
// Reset empties the table, zeroes the beat counter and live count and loads the
// register defaults; the block is ready in the first cycle after reset.
// When the receiver stalls, the finished result waits in the output register and
// s_tready stays low once the next request is ready to deliver its own result.
module heartbeat_node_liveness_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hnlt_pkg::PADDR_W-1:0]    paddr,
	input  logic [hnlt_pkg::PDATA_W-1:0]    pwdata,
	output logic [hnlt_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: node_id[7:0], slave_status[15:8], send_ok[16], motor_running[17], zero pad
	input  logic [hnlt_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [hnlt_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: send_beat[0], slave_fault[1], slave_lost[2], no_slave_error[3],
	//          table_full[4], live_count[8:5], zero pad
	output logic [hnlt_pkg::M_TDATA_W-1:0]  m_tdata
);
	import hnlt_pkg::*;

	cfg_t       cfg_q;
	slot_cmd_t  cmd;
	slot_stat_t stat;
	reg_idx_t   reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_mode    <= 1'b0;
			cfg_q.timeout_ms     <= '0;
			cfg_q.report_loss    <= 1'b0;
			cfg_q.master_node_id <= MASTER_ID_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MASTER_MODE: cfg_q.master_mode    <= pwdata[0];
				REG_TIMEOUT_MS:  cfg_q.timeout_ms     <= pwdata[TIMEOUT_W-1:0];
				REG_REPORT_LOSS: cfg_q.report_loss    <= pwdata[0];
				REG_MASTER_ID:   cfg_q.master_node_id <= pwdata[NODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_idx)
			REG_MASTER_MODE: prdata = PDATA_W'(cfg_q.master_mode);
			REG_TIMEOUT_MS:  prdata = PDATA_W'(cfg_q.timeout_ms);
			REG_REPORT_LOSS: prdata = PDATA_W'(cfg_q.report_loss);
			REG_MASTER_ID:   prdata = PDATA_W'(cfg_q.master_node_id);
			default:         prdata = '0;
		endcase
	end

	hnlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

	hnlt_slot_unit u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
